/* src/gbn_pkg.sv */
// Shared types, field widths and codes for the go-back-N sender.
package gbn_pkg;

    // Fixed field widths of the input and result beats.
    localparam int SEQ_W   = 20;
    localparam int CMD_W   = 2;
    localparam int COUNT_W = 24;

    // Configuration register widths.
    localparam int TOTAL_W   = 20;
    localparam int WIN_W     = 11;
    localparam int TIMEOUT_W = 16;

    // Configuration register reset values.
    localparam logic [TOTAL_W-1:0]   TOTAL_RESET   = 20'd20000;
    localparam logic [WIN_W-1:0]     WIN_RESET     = 11'd1;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1500;

    // Defaults for the top-level parameters.
    localparam int SEQ_BITS_DEF   = 20;
    localparam int TIMER_BITS_DEF = 16;

    // APB port geometry: three 32-bit registers at byte addresses 0, 4 and 8.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_TOTAL   = 2'd0,
        REG_WINDOW  = 2'd1,
        REG_TIMEOUT = 2'd2
    } gbn_reg_t;

    // Command codes of an input beat.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_RESTART = 2'd2
    } gbn_cmd_t;

    // Input beat payload.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SEQ_W-1:0] ack_value;
    } gbn_in_t;

    // Result beat payload.
    typedef struct packed {
        logic               send_valid;
        logic [SEQ_W-1:0]   send_seq;
        logic               is_resend;
        logic [COUNT_W-1:0] resend_total;
        logic               timed_out;
        logic [SEQ_W-1:0]   window_base;
        logic               done_res;
    } gbn_out_t;

endpackage

/* src/gbn_stream_if.sv */
// Valid/ready stream interface carrying one payload beat per handshake.
interface gbn_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/go_back_n_sender_top.sv */
// Go-back-N sender core: window, timer and resend tracking with an APB register port.
//
//  Channel   Role              Payload
//  req       sink, valid/ready gbn_in_t  (cmd, ack_value)
//  rsp       source, v/r       gbn_out_t (send_valid .. done_res)
//  apb       slave, write/read total_messages, window_size, timeout_ticks
//
//  Each beat passes an input register, then compare and count logic that updates the
//  sender state and loads the result register; one beat per cycle is sustained while rsp
//  does not stall, set by the single state-update step.
//  Reset (rst_n low, asynchronous) clears the sender state and both stage valids and
//  loads the register defaults.  A stalled rsp holds its beat; req keeps being taken
//  while the input register is empty or the result register can move on.
module go_back_n_sender_top
    import gbn_pkg::*;
#(
    parameter int SEQ_BITS   = SEQ_BITS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    gbn_stream_if.sink          req,
    gbn_stream_if.source        rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    // Widths for compares that must not wrap.
    localparam int CMP_W   = ((SEQ_BITS > TOTAL_W) ? SEQ_BITS : TOTAL_W) + 2;
    localparam int LIM_W   = ((TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W) + 1;
    localparam int TOT_EFF = (SEQ_BITS < TOTAL_W) ? SEQ_BITS : TOTAL_W;
    localparam int TMO_EFF = (TIMER_BITS < TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;
    localparam logic [TOTAL_W-1:0]   TOTAL_MASK   = TOTAL_W'((64'd1 << TOT_EFF) - 64'd1);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_MASK = TIMEOUT_W'((64'd1 << TMO_EFF) - 64'd1);
    localparam logic [COUNT_W-1:0]   COUNT_MAX    = '1;

    // Configuration registers.
    logic [TOTAL_W-1:0]   total_reg;
    logic [WIN_W-1:0]     window_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // Sender state.
    logic [SEQ_BITS-1:0]   base_reg, base_next;
    logic [SEQ_BITS-1:0]   nseq_reg, nseq_next;
    logic [SEQ_BITS-1:0]   hw_reg, hw_next;
    logic [TIMER_BITS-1:0] wait_reg, wait_next;
    logic [COUNT_W-1:0]    resend_reg, resend_next;

    // Pipeline registers.
    logic     in_valid_reg;
    gbn_in_t  in_data_reg;
    logic     out_valid_reg;
    gbn_out_t out_data_reg;
    gbn_out_t result;

    logic advance;
    logic proc;
    logic cfg_wr;
    gbn_reg_t reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = gbn_reg_t'(paddr[3:2]);

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= TOTAL_RESET & TOTAL_MASK;
            window_reg  <= WIN_RESET;
            timeout_reg <= TIMEOUT_RESET & TIMEOUT_MASK;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_TOTAL:   total_reg   <= pwdata[TOTAL_W-1:0] & TOTAL_MASK;
                REG_WINDOW:  window_reg  <= pwdata[WIN_W-1:0];
                REG_TIMEOUT: timeout_reg <= pwdata[TIMEOUT_W-1:0] & TIMEOUT_MASK;
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        unique case (reg_idx)
            REG_TOTAL:   prdata = PDATA_W'(total_reg);
            REG_WINDOW:  prdata = PDATA_W'(window_reg);
            REG_TIMEOUT: prdata = PDATA_W'(timeout_reg);
            default:     prdata = '0;
        endcase
    end

    // Handshake: the result register moves when empty or taken.
    assign advance   = !out_valid_reg || rsp.ready;
    assign proc      = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_data_reg <= req.data;
        end
    end

    // Per-beat state update and result.
    always_comb
    begin
        logic [SEQ_BITS-1:0]   ack_eff;
        logic [SEQ_BITS-1:0]   total_eff;
        logic [SEQ_BITS-1:0]   new_base;
        logic [SEQ_BITS-1:0]   seq_inc;
        logic [CMP_W-1:0]      win_end;
        logic [LIM_W-1:0]      limit;
        logic [LIM_W-1:0]      wait_inc;
        logic                  can_send;
        logic                  all_done;
        logic                  sv;
        logic [SEQ_BITS-1:0]   sq;
        logic                  rs;
        logic                  to;

        ack_eff   = SEQ_BITS'(in_data_reg.ack_value);
        total_eff = SEQ_BITS'(total_reg);
        win_end   = CMP_W'(base_reg) + CMP_W'(window_reg);
        can_send  = (CMP_W'(nseq_reg) < win_end) && (CMP_W'(nseq_reg) < CMP_W'(total_eff));
        all_done  = (CMP_W'(base_reg) >= CMP_W'(total_eff))
                    && (CMP_W'(nseq_reg) >= CMP_W'(total_eff));
        limit     = (timeout_reg == '0) ? LIM_W'(1) : LIM_W'(timeout_reg);
        wait_inc  = LIM_W'(wait_reg) + LIM_W'(1);
        seq_inc   = nseq_reg + SEQ_BITS'(1);
        new_base  = (CMP_W'(ack_eff) < CMP_W'(total_eff)) ? ack_eff : total_eff;

        base_next   = base_reg;
        nseq_next   = nseq_reg;
        hw_next     = hw_reg;
        wait_next   = wait_reg;
        resend_next = resend_reg;
        sv = 1'b0;
        sq = '0;
        rs = 1'b0;
        to = 1'b0;

        case (in_data_reg.cmd)
            CMD_TICK:
            begin
                if (can_send)
                begin
                    // Send the next number; below the high-water mark it is a resend.
                    sv = 1'b1;
                    sq = nseq_reg;
                    if (nseq_reg < hw_reg)
                    begin
                        rs = 1'b1;
                        if (resend_reg != COUNT_MAX)
                        begin
                            resend_next = resend_reg + COUNT_W'(1);
                        end
                    end
                    nseq_next = seq_inc;
                    if (seq_inc > hw_reg)
                    begin
                        hw_next = seq_inc;
                    end
                    wait_next = '0;
                end
                else if (!all_done)
                begin
                    // Idle tick: count toward the timeout, then go back to base.
                    if (wait_inc >= limit)
                    begin
                        nseq_next = base_reg;
                        wait_next = '0;
                        to = 1'b1;
                    end
                    else
                    begin
                        wait_next = TIMER_BITS'(wait_inc);
                    end
                end
            end
            CMD_ACK:
            begin
                if (ack_eff > base_reg)
                begin
                    base_next = new_base;
                    if (nseq_reg < new_base)
                    begin
                        nseq_next = new_base;
                    end
                end
                wait_next = '0;
            end
            CMD_RESTART:
            begin
                base_next   = '0;
                nseq_next   = '0;
                hw_next     = '0;
                wait_next   = '0;
                resend_next = '0;
            end
            default: ;
        endcase

        result.send_valid   = sv;
        result.send_seq     = SEQ_W'(sq);
        result.is_resend    = rs;
        result.resend_total = resend_next;
        result.timed_out    = to;
        result.window_base  = SEQ_W'(base_next);
        result.done_res     = CMP_W'(base_next) >= CMP_W'(total_eff);
    end

    // Sender state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            nseq_reg   <= '0;
            hw_reg     <= '0;
            wait_reg   <= '0;
            resend_reg <= '0;
        end
        else if (proc)
        begin
            base_reg   <= base_next;
            nseq_reg   <= nseq_next;
            hw_reg     <= hw_next;
            wait_reg   <= wait_next;
            resend_reg <= resend_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            out_data_reg <= result;
        end
    end

    // The next number to send never falls behind the window base.
    a_next_not_below_base: assert property (
        @(posedge clk) disable iff (!rst_n)
        nseq_reg >= base_reg
    ) else $error("next sequence number fell below the window base");

    // A beat that sends restarts the idle timer.
    a_send_clears_timer: assert property (
        @(posedge clk) disable iff (!rst_n)
        (proc && result.send_valid) |=> (wait_reg == '0)
    ) else $error("idle timer not cleared after a send");

    // A resend or a timeout only shows with the matching send state.
    a_result_flags: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((!out_data_reg.is_resend || out_data_reg.send_valid)
                           && !(out_data_reg.timed_out && out_data_reg.send_valid))
    ) else $error("inconsistent resend or timeout flags in result");

    // The resend count moves by at most one per processed beat, except on restart.
    a_resend_step: assert property (
        @(posedge clk) disable iff (!rst_n)
        (proc && in_data_reg.cmd != CMD_RESTART)
            |=> (resend_reg == $past(resend_reg)
                 || resend_reg == $past(resend_reg) + COUNT_W'(1))
    ) else $error("resend count jumped");

endmodule
